// ===== src/snf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// snf_pkg
// Shared types, constants and the log2 table of the spectral novelty block.
// ----------------------------------------------------------------------------
package snf_pkg;

  localparam int MAX_BINS = 1024;
  localparam int MAG_BITS = 24;
  localparam int ADDR_W   = $clog2(MAX_BINS);
  localparam int LEN_W    = 11;
  localparam int SUM_W    = 64;
  localparam int RAD_W    = 72;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int LOG_W    = 29;
  localparam int OUT_W    = 32;
  localparam int CFG_W    = 11;

  localparam logic [MAG_BITS-1:0] EPS_LSB = MAG_BITS'(10);

  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    MODE_FLUX   = 2'd0,
    MODE_HAINS  = 2'd1,
    MODE_LAROCH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_READ, S_FLX, S_LGX, S_LGP, S_LGD, S_SQX, S_WSX,
    S_SQP, S_WSP, S_ACC, S_FIN, S_WRT, S_WDV, S_OUT
  } state_t;

  function automatic logic [24:0] log_tab(input logic [4:0] k);
    logic [24:0] t;
    case (k)
      5'd0:    t = 25'd0;
      5'd1:    t = 25'd1467383;
      5'd2:    t = 25'd2850868;
      5'd3:    t = 25'd4159533;
      5'd4:    t = 25'd5401057;
      5'd5:    t = 25'd6581994;
      5'd6:    t = 25'd7707983;
      5'd7:    t = 25'd8783913;
      5'd8:    t = 25'd9814042;
      5'd9:    t = 25'd10802114;
      5'd10:   t = 25'd11751428;
      5'd11:   t = 25'd12664911;
      5'd12:   t = 25'd13545167;
      5'd13:   t = 25'd14394532;
      5'd14:   t = 25'd15215099;
      5'd15:   t = 25'd16008758;
      5'd16:   t = 25'd16777216;
      default: t = 25'd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== src/spectral_novelty_function.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spectral_novelty_function
// Spectral-flux onset novelty over blocks of magnitude bins.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 1024-entry previous-spectrum RAM to zero;
// configuration writes are taken during the sweep. Each bin then passes
// through the states of its mode, and magnitude_stall holds off the next bin
// until it is done. Root-difference mode uses the shared bit-serial square-root
// unit (36 steps per root, two roots per bin). The last bin of a block runs the
// 64-step divider, after the final root in flux mode; the fourth mode uses neither.
// ----------------------------------------------------------------------------
module spectral_novelty_function (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic                         cfg_index,
  input  wire logic [snf_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic [snf_pkg::MAG_BITS-1:0] magnitude,
  input  wire logic                         magnitude_valid,
  output logic                              magnitude_stall,
  output logic signed [snf_pkg::OUT_W-1:0]  novelty,
  output logic                              novelty_valid,
  input  wire logic                         novelty_stall
);
  import snf_pkg::*;

  state_t state, state_next;

  mode_t             mode;
  logic [LEN_W-1:0]  block_length;
  logic [LEN_W-1:0]  len_eff;
  logic [ADDR_W-1:0] bin_index;
  logic [ADDR_W-1:0] clr_addr;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  term;
  logic [MAG_BITS-1:0] x;
  logic [MAG_BITS-1:0] p;
  logic [ROOT_W-1:0] aux;
  logic              neg;
  logic [OUT_W-1:0]  res;
  logic              last;
  logic              accept;
  logic              load_out;

  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [MAG_BITS-1:0] ram_wdata;
  logic [MAG_BITS-1:0] ram_rdata;

  logic              sq_start, sq_busy, sq_done;
  logic [RAD_W-1:0]  sq_rad;
  logic [ROOT_W-1:0] sq_root;
  logic              dv_start, dv_busy, dv_done;
  logic [SUM_W-1:0]  dv_num;
  logic [SUM_W-1:0]  dv_quot;
  logic [MAG_BITS-1:0] lg_in;
  logic [LOG_W-1:0]  lg_out;

  logic [SUM_W-1:0]    sum_abs;
  logic [SUM_W:0]      sum_add;
  logic [2*MAG_BITS-1:0] sq_diff;
  logic [MAG_BITS-1:0] xe;
  logic [MAG_BITS-1:0] pe;
  logic [LOG_W:0]      log_diff;

  assign len_eff = (block_length == '0) ? LEN_W'(1) :
                   (block_length > LEN_W'(MAX_BINS)) ? LEN_W'(MAX_BINS) : block_length;
  assign last    = ({1'b0, bin_index} + 1'b1) >= len_eff;
  assign accept  = magnitude_valid && !magnitude_stall;
  assign magnitude_stall = (state != S_IDLE);
  assign load_out = (state == S_OUT) && (!novelty_valid || !novelty_stall);

  assign xe       = (x == '0) ? EPS_LSB : x;
  assign pe       = (p == '0) ? EPS_LSB : p;
  assign sq_diff  = (x - p) * (x - p);
  assign sum_add  = {1'b0, sum} + {1'b0, term};
  assign sum_abs  = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
  assign log_diff = {1'b0, aux[LOG_W-1:0]} - {1'b0, lg_out};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_FLUX;
      block_length <= LEN_W'(MAX_BINS);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MODE:   mode <= mode_t'(cfg_data[1:0]);
        CFG_LENGTH: block_length <= cfg_data[LEN_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = bin_index;
    ram_wdata  = x;
    sq_start   = 1'b0;
    sq_rad     = {{(RAD_W - MAG_BITS - 28){1'b0}}, x, 28'b0};
    dv_start   = 1'b0;
    dv_num     = sum_abs;
    lg_in      = xe;
    unique case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
        if (clr_addr == ADDR_W'(MAX_BINS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_re = magnitude_valid;
        if (magnitude_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        ram_we = 1'b1;
        unique case (mode)
          MODE_FLUX:   state_next = S_FLX;
          MODE_HAINS:  state_next = S_LGX;
          MODE_LAROCH: state_next = S_SQX;
          default:     state_next = S_ACC;
        endcase
      end
      S_FLX: state_next = S_ACC;
      S_LGX: state_next = S_LGP;
      S_LGP: begin
        lg_in      = pe;
        state_next = S_LGD;
      end
      S_LGD: state_next = S_ACC;
      S_SQX: begin
        sq_start   = 1'b1;
        state_next = S_WSX;
      end
      S_WSX: begin
        if (sq_done) begin
          state_next = S_SQP;
        end
      end
      S_SQP: begin
        sq_start   = 1'b1;
        sq_rad     = {{(RAD_W - MAG_BITS - 28){1'b0}}, p, 28'b0};
        state_next = S_WSP;
      end
      S_WSP: begin
        if (sq_done) begin
          state_next = S_ACC;
        end
      end
      S_ACC: state_next = last ? S_FIN : S_IDLE;
      S_FIN: begin
        sq_rad = {sum, 8'b0};
        unique case (mode)
          MODE_FLUX: begin
            sq_start   = 1'b1;
            state_next = S_WRT;
          end
          MODE_HAINS, MODE_LAROCH: begin
            dv_start   = 1'b1;
            state_next = S_WDV;
          end
          default: state_next = S_OUT;
        endcase
      end
      S_WRT: begin
        dv_num = {{(SUM_W - ROOT_W){1'b0}}, sq_root};
        if (sq_done) begin
          dv_start   = 1'b1;
          state_next = S_WDV;
        end
      end
      S_WDV: begin
        if (dv_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr      <= '0;
      bin_index     <= '0;
      sum           <= '0;
      novelty_valid <= 1'b0;
    end else begin
      if (state == S_CLR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_ACC) begin
        bin_index <= bin_index + 1'b1;
        if (mode == MODE_FLUX) begin
          sum <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        end else begin
          sum <= sum_add[SUM_W-1:0];
        end
      end
      if (load_out) begin
        sum           <= '0;
        bin_index     <= '0;
        novelty_valid <= 1'b1;
      end else if (novelty_valid && !novelty_stall) begin
        novelty_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x <= magnitude;
    end
    if (state == S_READ) begin
      p    <= ram_rdata;
      term <= '0;
    end
    if (state == S_FLX && x > p) begin
      term <= {{(SUM_W - 2*MAG_BITS){1'b0}}, sq_diff};
    end
    if (state == S_LGP) begin
      aux <= {{(ROOT_W - LOG_W){1'b0}}, lg_out};
    end
    if (state == S_LGD) begin
      term <= {{(SUM_W - LOG_W - 1){log_diff[LOG_W]}}, log_diff};
    end
    if (state == S_WSX && sq_done) begin
      aux <= sq_root;
    end
    if (state == S_WSP && sq_done) begin
      term <= (aux > sq_root) ? {{(SUM_W - ROOT_W){1'b0}}, aux - sq_root} : '0;
    end
    if (state == S_FIN) begin
      neg <= sum[SUM_W-1] && (mode != MODE_FLUX);
      res <= '0;
    end
    if (state == S_WDV && dv_done) begin
      if (neg) begin
        res <= (dv_quot > SUM_W'(64'h8000_0000)) ? OUT_W'(32'h8000_0000) :
               OUT_W'(~dv_quot + 1'b1);
      end else begin
        res <= (dv_quot > SUM_W'(64'h7FFF_FFFF)) ? OUT_W'(32'h7FFF_FFFF) :
               dv_quot[OUT_W-1:0];
      end
    end
    if (load_out) begin
      novelty <= res;
    end
  end

  snf_ram #(.WIDTH(MAG_BITS), .DEPTH(MAX_BINS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  snf_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .busy     (sq_busy),
    .done     (sq_done),
    .root     (sq_root)
  );

  snf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (len_eff),
    .busy  (dv_busy),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  snf_log u_log (
    .clk     (clk),
    .value   (lg_in),
    .log_out (lg_out)
  );

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(sq_busy && dv_busy))
    else $error("root and divide units busy together");

  a_clear_after_out: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (sum == '0) && (bin_index == '0) && novelty_valid)
    else $error("block state not cleared after result");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> (state == S_WDV))
    else $error("divider finished outside wait state");

endmodule
`default_nettype wire

// ===== src/snf_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// snf_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module snf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule
`default_nettype wire

// ===== src/snf_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// snf_sqrt
// Iterative floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module snf_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [snf_pkg::RAD_W-1:0] radicand,
  output logic                           busy,
  output logic                           done,
  output logic [snf_pkg::ROOT_W-1:0]     root
);
  import snf_pkg::*;

  logic [RAD_W-1:0]            rad;
  logic [ROOT_W+1:0]           rem;
  logic [$clog2(ROOT_W)-1:0]   count;
  logic [ROOT_W+1:0]           rem_s;
  logic [ROOT_W+1:0]           trial;

  assign rem_s = {rem[ROOT_W-1:0], rad[RAD_W-1:RAD_W-2]};
  assign trial = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad   <= radicand;
      rem   <= '0;
      root  <= '0;
      count <= ($clog2(ROOT_W))'(ROOT_W - 1);
    end else if (busy) begin
      rad   <= {rad[RAD_W-3:0], 2'b00};
      count <= count - 1'b1;
      if (rem_s >= trial) begin
        rem  <= rem_s - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_s;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/snf_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// snf_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module snf_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [snf_pkg::SUM_W-1:0] num,
  input  wire logic [snf_pkg::LEN_W-1:0] den,
  output logic                           busy,
  output logic                           done,
  output logic [snf_pkg::SUM_W-1:0]      quot
);
  import snf_pkg::*;

  logic [LEN_W-1:0]           divisor;
  logic [LEN_W-1:0]           rem;
  logic [$clog2(SUM_W)-1:0]   count;
  logic [LEN_W:0]             rem_s;

  assign rem_s = {rem, quot[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot    <= num;
      divisor <= den;
      rem     <= '0;
      count   <= ($clog2(SUM_W))'(SUM_W - 1);
    end else if (busy) begin
      count <= count - 1'b1;
      if (rem_s >= {1'b0, divisor}) begin
        rem  <= LEN_W'(rem_s - {1'b0, divisor});
        quot <= {quot[SUM_W-2:0], 1'b1};
      end else begin
        rem  <= rem_s[LEN_W-1:0];
        quot <= {quot[SUM_W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/snf_log.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// snf_log
// Table-interpolated log2 in Q.24 with a registered result.
// ----------------------------------------------------------------------------
module snf_log (
  input  wire logic                         clk,
  input  wire logic [snf_pkg::MAG_BITS-1:0] value,
  output logic      [snf_pkg::LOG_W-1:0]    log_out
);
  import snf_pkg::*;

  logic [4:0]  e;
  logic [4:0]  sh;
  logic [31:0] f;
  logic [3:0]  idx;
  logic [23:0] r;
  logic [24:0] t0;
  logic [24:0] dt;
  logic [48:0] prod;

  always_comb begin
    e = '0;
    for (int k = 0; k < MAG_BITS; k++) begin
      if (value[k]) begin
        e = 5'(k);
      end
    end
    sh   = 5'd31 - e;
    f    = {{(32 - MAG_BITS){1'b0}}, value} << sh;
    idx  = f[30:27];
    r    = f[26:3];
    t0   = log_tab({1'b0, idx});
    dt   = log_tab({1'b0, idx} + 5'd1) - t0;
    prod = {24'b0, dt} * {25'b0, r};
  end

  always_ff @(posedge clk) begin
    log_out <= {e, 24'b0} + {4'b0, t0} + {4'b0, prod[48:24]};
  end
endmodule
`default_nettype wire

// ===== test/spectral_novelty_function_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spectral_novelty_function_tb
// Self-checking bench for the spectral novelty block: magnitude bins go in
// under random idling, each finished block's novelty value is predicted
// bit-exactly and compared; mode and block length change between phases.
// ----------------------------------------------------------------------------

class novelty_scoreboard;
  localparam int BINS = snf_pkg::MAX_BINS;

  logic [31:0]    pending_novelty[$];
  logic [23:0]    prev_spectrum[BINS];
  logic [63:0]    flux_sum;
  int unsigned    bin_count;
  snf_pkg::mode_t measure;
  logic [10:0]    length_reg;
  int             mismatches;
  int             results_seen;
  int             inputs_seen;
  logic [24:0]    lg_tab[17];

  function new();
    lg_tab = '{25'd0, 25'd1467383, 25'd2850868, 25'd4159533, 25'd5401057,
               25'd6581994, 25'd7707983, 25'd8783913, 25'd9814042,
               25'd10802114, 25'd11751428, 25'd12664911, 25'd13545167,
               25'd14394532, 25'd15215099, 25'd16008758, 25'd16777216};
    foreach (prev_spectrum[i]) prev_spectrum[i] = '0;
    flux_sum = '0;
    bin_count = 0;
    measure = snf_pkg::MODE_FLUX;
    length_reg = 11'd1024;
    mismatches = 0;
    results_seen = 0;
    inputs_seen = 0;
  endfunction

  function void set_register(logic index, logic [10:0] value);
    if (index == snf_pkg::CFG_MODE) measure = snf_pkg::mode_t'(value[1:0]);
    else length_reg = value;
  endfunction

  // floor(sqrt(v * 4^fpairs))
  function logic [63:0] frac_root(logic [63:0] v, int fpairs);
    logic [63:0] rem, root, trial, pair;
    rem = '0;
    root = '0;
    for (int i = 31 + fpairs; i >= 0; i--) begin
      pair = (i >= fpairs) ? ((v >> (2 * (i - fpairs))) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function logic [63:0] log2_q24(logic [63:0] v);
    int e;
    logic [63:0] f, r, d;
    int idx;
    e = 31;
    while (e > 0 && v[e] == 1'b0) e--;
    f = (v << (31 - e)) & 64'h7FFF_FFFF;
    idx = int'(f >> 27);
    r = (f >> 3) & 64'hFF_FFFF;
    d = 64'(lg_tab[idx + 1] - lg_tab[idx]);
    return (64'(e) << 24) + 64'(lg_tab[idx]) + ((d * r) >> 24);
  endfunction

  function logic [31:0] signed_quotient(logic [63:0] acc, int unsigned len);
    logic [63:0] mag, q;
    mag = acc[63] ? (~acc + 64'd1) : acc;
    q = mag / 64'(len);
    if (acc[63]) return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q);
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function void note_bin(logic [23:0] x);
    int unsigned len, slot;
    logic [63:0] p, xe, pe, d, sx, sp, q;
    logic [31:0] res;
    inputs_seen++;
    len = (length_reg == 0) ? 1 : ((length_reg > BINS) ? BINS : length_reg);
    slot = bin_count % BINS;
    p = 64'(prev_spectrum[slot]);
    case (measure)
      snf_pkg::MODE_FLUX: begin
        if (64'(x) > p) begin
          d = 64'(x) - p;
          d = d * d;
          flux_sum = (flux_sum > ~d) ? '1 : flux_sum + d;
        end
      end
      snf_pkg::MODE_HAINS: begin
        xe = (x == 0) ? 64'd10 : 64'(x);
        pe = (p == 0) ? 64'd10 : p;
        flux_sum = flux_sum + log2_q24(xe) - log2_q24(pe);
      end
      snf_pkg::MODE_LAROCH: begin
        sx = frac_root(64'(x), 14);
        sp = frac_root(p, 14);
        if (sx > sp) flux_sum = flux_sum + sx - sp;
      end
      default: ;
    endcase
    prev_spectrum[slot] = x;
    bin_count++;
    if (bin_count < len) return;
    case (measure)
      snf_pkg::MODE_FLUX: begin
        q = frac_root(flux_sum, 4) / 64'(len);
        res = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end
      snf_pkg::MODE_HAINS, snf_pkg::MODE_LAROCH: res = signed_quotient(flux_sum, len);
      default: res = '0;
    endcase
    pending_novelty.push_back(res);
    flux_sum = '0;
    bin_count = 0;
  endfunction

  function void check_novelty(logic [31:0] got);
    logic [31:0] want;
    results_seen++;
    if (pending_novelty.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected novelty %h", got);
      return;
    end
    want = pending_novelty.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("novelty mismatch: expected %h actual %h", want, got);
    end
  endfunction
endclass

module spectral_novelty_function_tb;
  import snf_pkg::*;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic              cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic [23:0]       magnitude;
  logic              magnitude_valid;
  logic              magnitude_stall;
  logic signed [31:0] novelty;
  logic              novelty_valid;
  logic              novelty_stall;

  novelty_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off;
  longint cycles;
  localparam longint CYCLE_LIMIT = 1_500_000;

  spectral_novelty_function dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .magnitude(magnitude), .magnitude_valid(magnitude_valid),
    .magnitude_stall(magnitude_stall), .novelty(novelty),
    .novelty_valid(novelty_valid), .novelty_stall(novelty_stall)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side: check, then pick the stall for the next cycle
  initial begin
    novelty_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && novelty_valid && !novelty_stall) sb.check_novelty(novelty);
      novelty_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(logic index, logic [10:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_register(index, value);
  endtask

  task automatic send_bin(logic [23:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      magnitude_valid <= 1'b0;
      @(posedge clk);
    end
    magnitude <= x;
    magnitude_valid <= 1'b1;
    do @(posedge clk); while (magnitude_stall);
    sb.note_bin(x);
  endtask

  task automatic drain();
    magnitude_valid <= 1'b0;
    while (sb.pending_novelty.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_pace(int idx);
    case (idx % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
      default: begin send_idle_pct = 31; recv_stall_pct = 31; end
    endcase
  endtask

  function automatic logic [23:0] pick_magnitude();
    case ($urandom_range(9))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      2: return 24'($urandom_range(20));
      3: return 24'($urandom) >> $urandom_range(23);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic run_phase(mode_t m, logic [10:0] len, int count, int pace);
    drain();
    write_reg(CFG_MODE, 11'(m));
    write_reg(CFG_LENGTH, len);
    set_pace(pace);
    for (int i = 0; i < count; i++) send_bin(pick_magnitude());
  endtask

  initial begin
    logic [10:0] len;
    int count;
    int phase;
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data = '0;
    magnitude = '0;
    magnitude_valid = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every mode, zero bins, odd lengths
    write_reg(CFG_MODE, 11'(MODE_FLUX));
    write_reg(CFG_LENGTH, 11'd1);
    send_bin(24'hFF_FFFF); send_bin(24'd0); send_bin(24'hFF_FFFF); send_bin(24'd1);
    drain();
    write_reg(CFG_MODE, 11'(MODE_HAINS));
    send_bin(24'd0); send_bin(24'hFF_FFFF); send_bin(24'd0); send_bin(24'd10);
    send_bin(24'd5);
    drain();
    write_reg(CFG_MODE, 11'(MODE_LAROCH));
    write_reg(CFG_LENGTH, 11'd2);
    send_bin(24'hFF_FFFF); send_bin(24'd0); send_bin(24'd0); send_bin(24'hFF_FFFF);
    drain();
    write_reg(CFG_MODE, 11'(MODE_NONE));
    write_reg(CFG_LENGTH, 11'd0);
    send_bin(24'h12_3456); send_bin(24'd7);
    drain();
    write_reg(CFG_MODE, 11'(MODE_HAINS));
    write_reg(CFG_LENGTH, 11'd3);
    send_bin(24'd1); send_bin(24'hFF_FFFF);
    drain();
    write_reg(CFG_LENGTH, 11'd1);   // lowered below the current bin count
    send_bin(24'h80_0000);
    drain();
    write_reg(CFG_LENGTH, 11'd3);
    send_bin(24'd3);
    drain();
    write_reg(CFG_MODE, 11'(MODE_FLUX)); // mode changed mid-block
    send_bin(24'hAB_CDEF); send_bin(24'h00_0001);

    // long receiver hold-off with the sender still pushing
    drain();
    write_reg(CFG_LENGTH, 11'd1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork begin
      hold_off = 1'b1;
      repeat (3000) @(posedge clk);
      hold_off = 1'b0;
    end join_none
    for (int i = 0; i < 40; i++) send_bin(pick_magnitude());

    run_phase(MODE_HAINS, 11'd2047, 400, 3);

    phase = 0;
    while (sb.inputs_seen < 850) begin
      case ($urandom_range(9))
        0: len = 11'd0;
        1: len = 11'd1;
        2: len = 11'($urandom_range(40, 100));
        default: len = 11'($urandom_range(2, 12));
      endcase
      count = (len == 0 ? 1 : int'(len)) * $urandom_range(1, 4) + $urandom_range(0, 3);
      if (count > 850 - sb.inputs_seen) count = 850 - sb.inputs_seen;
      run_phase(mode_t'(phase % 4), len, count, phase + phase / 4);
      phase++;
    end

    drain();
    $display("%0d bins sent, %0d novelty values checked over %0d random phases",
             sb.inputs_seen, sb.results_seen, phase);
    $display("all four modes, lengths 0 to 2047, idle and stall mixes, long hold-off");
    if (sb.mismatches == 0 && sb.pending_novelty.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches,
               sb.pending_novelty.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
